// ----- rtl/core/rfd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the rail fence decryption block: shared constants, register
// indexes and the control struct that drives the zigzag index generator.
// Depends on nothing.

package rfd_pkg;

    localparam int CHAR_W     = 8;
    localparam int RAIL_W     = 5;
    localparam int PASS_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_RAIL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_COUNT = 2'd1;

    localparam logic [RAIL_W-1:0] RAIL_COUNT_RESET = 5'd3;
    localparam logic [PASS_W-1:0] PASS_COUNT_RESET = 4'd1;

    typedef struct packed {
        logic init;
        logic adv;
    } zig_ctl_t;

endpackage

// ----- rtl/core/rfd_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with one write port and one registered
// read port. Uses no package.

module rfd_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/rfd_zigzag.sv -----
`timescale 1ns / 1ps
// Zigzag index generator: for each ciphertext position in turn it gives the
// plaintext position it belongs to, rail by rail. Depends on rfd_pkg.

module rfd_zigzag #(
    parameter int LEN_W = 7,
    parameter int IDX_W = 7,
    parameter int ADDR_W = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [rfd_pkg::RAIL_W-1:0] rows,
    input  logic [LEN_W-1:0]          msg_len,
    input  rfd_pkg::zig_ctl_t         ctl,
    output logic [ADDR_W-1:0]         idx
);

    localparam int STEP_W = rfd_pkg::RAIL_W + 1;

    logic [rfd_pkg::RAIL_W-1:0] rail_reg, rail_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic                       phase_reg, phase_next;

    logic [STEP_W-1:0] cycle_len;
    logic [STEP_W-1:0] two_rail;
    logic [STEP_W-1:0] step;
    logic [IDX_W-1:0]  sum;
    logic              outer_rail;

    always_comb begin
        cycle_len  = {rows, 1'b0} - STEP_W'(2);
        two_rail   = {rail_reg, 1'b0};
        outer_rail = (rail_reg == '0) || (rail_reg == rows - rfd_pkg::RAIL_W'(1));
        if (outer_rail) begin
            step = cycle_len;
        end else if (phase_reg) begin
            step = two_rail;
        end else begin
            step = cycle_len - two_rail;
        end
        sum = idx_reg + IDX_W'(step);

        rail_next  = rail_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        if (ctl.init) begin
            rail_next  = '0;
            idx_next   = '0;
            phase_next = 1'b0;
        end else if (ctl.adv) begin
            if (sum < IDX_W'(msg_len)) begin
                idx_next   = sum;
                phase_next = ~phase_reg;
            end else begin
                rail_next  = rail_reg + rfd_pkg::RAIL_W'(1);
                idx_next   = IDX_W'(rail_reg) + IDX_W'(1);
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rail_reg  <= '0;
            idx_reg   <= '0;
            phase_reg <= 1'b0;
        end else begin
            rail_reg  <= rail_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    assign idx = idx_reg[ADDR_W-1:0];

endmodule

// ----- rtl/core/rail_fence_decrypt.sv -----
`timescale 1ns / 1ps
// Top level of the rail fence decryption block: load, pass and emit control
// around two ping-pong message RAMs. Depends on rfd_pkg, rfd_ram, rfd_zigzag.
//
// Usage. Ciphertext bytes enter on the s_ channel, one per transaction, and
// are taken at one per cycle while a message is being loaded. Spaces are
// dropped, capitals are lowercased, and bytes beyond MAX_LEN are dropped with
// the truncated flag raised on every result of that message. The transaction
// with s_last_in set ends the message; s_ready then stays low until the last
// plaintext byte has left on the m_ channel.
// Each decryption pass scatters the stored bytes from one RAM into the other
// in zigzag order at one byte per cycle. After the final input byte the
// passes run, or none when fewer than two rails are configured; the first
// byte is then read from the RAM and loaded into the output register. Each
// later result loads only once the previous one is taken, so m_valid drops
// between results. A stalled receiver holds the output register and the
// block. A message that stores no byte produces no result at all.
// The cfg channel is always ready; index 0 sets the rail count and index 1
// the pass count, and both may only change between messages.
// Reset is synchronous: the block comes up empty, ready for a new message,
// with three rails and one pass.

module rail_fence_decrypt #(
    parameter int MAX_LEN   = 64,
    parameter int MAX_RAILS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rfd_pkg::CHAR_W-1:0]         s_char_in,
    input  logic                               s_last_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rfd_pkg::CHAR_W-1:0]         m_char_out,
    output logic                               m_last_out,
    output logic                               m_truncated,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int IDX_W    = $clog2(MAX_LEN + 2 ** (rfd_pkg::RAIL_W + 1));
    localparam int RAIL_CAP = (MAX_RAILS < 31) ? MAX_RAILS : 31;
    localparam int CW       = rfd_pkg::CHAR_W;
    localparam int RW       = rfd_pkg::RAIL_W;
    localparam int PW       = rfd_pkg::PASS_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS_INIT,
        S_PASS_RUN,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_HOLD
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic [RW-1:0]    rail_cfg_reg, rail_cfg_next;
    logic [PW-1:0]    pass_cfg_reg, pass_cfg_next;
    logic [PW-1:0]    pass_cnt_reg, pass_cnt_next;
    logic             src_sel_reg, src_sel_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] k_reg, k_next;
    logic             wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic             out_valid_reg, out_valid_next;
    logic [CW-1:0]    out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;
    logic             out_trunc_reg, out_trunc_next;

    logic [RW-1:0]     rows;
    logic [PW-1:0]     passes;
    logic [CW-1:0]     char_lc;
    logic              keep_char;
    logic              load_we;
    logic [LEN_W-1:0]  new_len;
    logic [ADDR_W-1:0] raddr;
    logic [CW-1:0]     rdata0, rdata1, src_data;
    logic              we0, we1;
    logic [ADDR_W-1:0] waddr0, waddr1;
    logic [CW-1:0]     wdata0, wdata1;
    logic [ADDR_W-1:0] zig_idx;
    rfd_pkg::zig_ctl_t zig_ctl;

    assign rows = (rail_cfg_reg > RW'(RAIL_CAP)) ? RW'(RAIL_CAP) : rail_cfg_reg;
    assign passes = (pass_cfg_reg == '0) ? PW'(1) : pass_cfg_reg;
    assign src_data = src_sel_reg ? rdata1 : rdata0;

    assign s_ready     = (state_reg == S_LOAD);
    assign cfg_ready   = 1'b1;
    assign m_valid     = out_valid_reg;
    assign m_char_out  = out_char_reg;
    assign m_last_out  = out_last_reg;
    assign m_truncated = out_trunc_reg;

    always_comb begin
        char_lc = s_char_in;
        if ((s_char_in >= rfd_pkg::CHAR_UPPER_A) && (s_char_in <= rfd_pkg::CHAR_UPPER_Z)) begin
            char_lc = s_char_in + rfd_pkg::CASE_OFFSET;
        end
        keep_char = (s_char_in != rfd_pkg::CHAR_SPACE) && (len_reg < LEN_W'(MAX_LEN));
        new_len   = keep_char ? len_reg + LEN_W'(1) : len_reg;
    end

    // The scatter writes always go to the RAM that is not being read.
    always_comb begin
        we0    = 1'b0;
        we1    = 1'b0;
        waddr0 = wr_addr_reg;
        waddr1 = wr_addr_reg;
        wdata0 = src_data;
        wdata1 = src_data;
        if (load_we) begin
            we0    = 1'b1;
            waddr0 = len_reg[ADDR_W-1:0];
            wdata0 = char_lc;
        end else if (wr_pend_reg) begin
            we0 = src_sel_reg;
            we1 = ~src_sel_reg;
        end
    end

    always_comb begin
        case (state_reg)
            S_PASS_RUN:  raddr = pos_reg[ADDR_W-1:0];
            S_EMIT_HOLD: raddr = ADDR_W'(k_reg + LEN_W'(1));
            default:     raddr = k_reg[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        rail_cfg_next  = rail_cfg_reg;
        pass_cfg_next  = pass_cfg_reg;
        pass_cnt_next  = pass_cnt_reg;
        src_sel_next   = src_sel_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = zig_idx;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_trunc_next = out_trunc_reg;
        load_we        = 1'b0;
        zig_ctl        = '0;

        if (cfg_valid) begin
            case (cfg_index)
                rfd_pkg::CFG_RAIL_COUNT: rail_cfg_next = cfg_data[RW-1:0];
                rfd_pkg::CFG_PASS_COUNT: pass_cfg_next = cfg_data[PW-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    load_we  = keep_char;
                    len_next = new_len;
                    if (s_char_in != rfd_pkg::CHAR_SPACE && !keep_char) begin
                        ovf_next = 1'b1;
                    end
                    if (s_last_in) begin
                        src_sel_next  = 1'b0;
                        pass_cnt_next = '0;
                        k_next        = '0;
                        if (new_len == '0) begin
                            ovf_next = 1'b0;
                        end else if (rows < RW'(2)) begin
                            state_next = S_EMIT_RD;
                        end else begin
                            state_next = S_PASS_INIT;
                        end
                    end
                end
            end
            S_PASS_INIT: begin
                zig_ctl.init = 1'b1;
                pos_next     = '0;
                state_next   = S_PASS_RUN;
            end
            S_PASS_RUN: begin
                if (pos_reg < len_reg) begin
                    zig_ctl.adv  = 1'b1;
                    pos_next     = pos_reg + LEN_W'(1);
                    wr_pend_next = 1'b1;
                end else begin
                    src_sel_next  = ~src_sel_reg;
                    pass_cnt_next = pass_cnt_reg + PW'(1);
                    if ((pass_cnt_reg + PW'(1)) < passes) begin
                        state_next = S_PASS_INIT;
                    end else begin
                        k_next     = '0;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_RD: begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                out_valid_next = 1'b1;
                out_char_next  = src_data;
                out_last_next  = (k_reg + LEN_W'(1)) == len_reg;
                out_trunc_next = ovf_reg;
                state_next     = S_EMIT_HOLD;
            end
            S_EMIT_HOLD: begin
                if (m_ready) begin
                    out_valid_next = 1'b0;
                    if (out_last_reg) begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        k_next     = k_reg + LEN_W'(1);
                        state_next = S_EMIT_LD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            rail_cfg_reg  <= rfd_pkg::RAIL_COUNT_RESET;
            pass_cfg_reg  <= rfd_pkg::PASS_COUNT_RESET;
            pass_cnt_reg  <= '0;
            src_sel_reg   <= 1'b0;
            pos_reg       <= '0;
            k_reg         <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            rail_cfg_reg  <= rail_cfg_next;
            pass_cfg_reg  <= pass_cfg_next;
            pass_cnt_reg  <= pass_cnt_next;
            src_sel_reg   <= src_sel_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
        wr_addr_reg   <= wr_addr_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
    end

    rfd_ram #(
        .DEPTH  (MAX_LEN),
        .ADDR_W (ADDR_W),
        .DATA_W (CW)
    ) u_ram0 (
        .aclk  (aclk),
        .we    (we0),
        .waddr (waddr0),
        .wdata (wdata0),
        .raddr (raddr),
        .rdata (rdata0)
    );

    rfd_ram #(
        .DEPTH  (MAX_LEN),
        .ADDR_W (ADDR_W),
        .DATA_W (CW)
    ) u_ram1 (
        .aclk  (aclk),
        .we    (we1),
        .waddr (waddr1),
        .wdata (wdata1),
        .raddr (raddr),
        .rdata (rdata1)
    );

    rfd_zigzag #(
        .LEN_W  (LEN_W),
        .IDX_W  (IDX_W),
        .ADDR_W (ADDR_W)
    ) u_zigzag (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rows    (rows),
        .msg_len (len_reg),
        .ctl     (zig_ctl),
        .idx     (zig_idx)
    );

endmodule

// ----- rtl/core/rfd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the rail fence decryption block, bound to the top
// level. Depends on rfd_pkg and rail_fence_decrypt.

module rfd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           s_last_in,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [rfd_pkg::CHAR_W-1:0]     m_char_out,
    input logic                           m_last_out,
    input logic                           m_truncated
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_out)
            && $stable(m_last_out) && $stable(m_truncated))
        else $error("result changed while stalled");

    // No input is taken while plaintext is being delivered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready during output");

    // The final result of a message returns the block to loading.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_out |=> !m_valid && s_ready)
        else $error("block did not return to loading after last result");

    // A byte that does not end the message keeps the block loading.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last_in |=> s_ready && !m_valid)
        else $error("block left loading before the last byte");

endmodule

bind rail_fence_decrypt rfd_checker u_rfd_checker (.*);
